/* design/atan2_octant_lookup_core_macros.svh */
`ifndef ATAN2_OCTANT_LOOKUP_CORE_MACROS_SVH
`define ATAN2_OCTANT_LOOKUP_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, held off during reset
`define A2OL_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, held off during reset
`define A2OL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/a2ol_pkg.sv */
`timescale 1ns / 1ps

package a2ol_pkg;

    localparam int ANGLE_W      = 11;
    localparam int OCT_W        = 9;
    localparam int ATAN_LAST    = 128;
    localparam int QUARTER_TURN = 256;
    localparam int HALF_TURN    = 512;
    localparam int FULL_TURN    = 1024;

    localparam int          TRIG_STEPS   = 128;
    localparam int          SERIES_TERMS = 14;
    localparam logic [63:0] PI_Q60       = 64'h3243F6A8885A308D;
    localparam logic [63:0] ONE_Q60      = 64'h1000000000000000;

    // per-request octant information carried down the pipe
    typedef struct packed {
        logic zero;
        logic steep;
        logic neg_x;
        logic neg_y;
    } a2ol_oct_t;

    typedef logic [63:0] a2ol_trig_t [0:TRIG_STEPS-1];

    // (a * b) >> 60 on a full-width product
    function automatic logic [63:0] mul_q60(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = 128'(a) * 128'(b);
        return p[123:60];
    endfunction

    // sine or cosine of k*pi/512 in Q50, series in Q60; elaboration only
    function automatic a2ol_trig_t trig_tab(input logic want_cos);
        a2ol_trig_t  tab;
        logic [63:0] a;
        logic [63:0] a2;
        logic [63:0] t;
        logic [63:0] s;
        logic [63:0] c;
        for (int k = 0; k < TRIG_STEPS; k++) begin
            a  = (PI_Q60 >> 9) * 64'(k);
            a2 = mul_q60(a, a);
            t  = a;
            s  = a;
            c  = ONE_Q60;
            for (int m = 1; m <= SERIES_TERMS; m++) begin
                t = mul_q60(t, a2) / 64'((2 * m) * (2 * m + 1));
                s = m[0] ? s - t : s + t;
            end
            t = ONE_Q60;
            for (int m = 1; m <= SERIES_TERMS; m++) begin
                t = mul_q60(t, a2) / 64'((2 * m - 1) * (2 * m));
                c = m[0] ? c - t : c + t;
            end
            tab[k] = want_cos ? (c >> 10) : (s >> 10);
        end
        return tab;
    endfunction

    // largest k with tan(k*pi/512) <= i/n; the last entry is a full octant
    function automatic logic [7:0] atan_entry(input int i, input int n,
                                              input a2ol_trig_t sn, input a2ol_trig_t cs);
        logic [127:0] lhs;
        logic [127:0] rhs;
        logic         run;
        logic [7:0]   ent;
        ent = '0;
        run = 1'b1;
        if (i >= n) begin
            ent = 8'(ATAN_LAST);
        end
        else begin
            for (int k = 1; k < TRIG_STEPS; k++) begin
                lhs = 128'(sn[k]) * 128'(n);
                rhs = 128'(cs[k]) * 128'(i);
                if (run && (lhs <= rhs)) begin
                    ent = 8'(k);
                end
                else begin
                    run = 1'b0;
                end
            end
        end
        return ent;
    endfunction

endpackage

/* design/a2ol_front.sv */
`timescale 1ns / 1ps
`include "atan2_octant_lookup_core_macros.svh"

module a2ol_front import a2ol_pkg::*; #(
    parameter int COORD_BITS = 16,
    parameter int QUO_BITS   = 9,
    parameter int TABLE_SIZE = 256
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  up_valid,
    output logic                  up_ready,
    input  logic [COORD_BITS-1:0] delta_y,
    input  logic [COORD_BITS-1:0] delta_x,
    output logic                  dn_valid,
    input  logic                  dn_ready,
    output logic [COORD_BITS-1:0] rem,
    output logic [QUO_BITS-1:0]   low,
    output logic [COORD_BITS-1:0] den,
    output a2ol_oct_t             oct
);

    localparam int PROD_W = COORD_BITS + QUO_BITS;

    logic                  a_valid_reg;
    logic [COORD_BITS-1:0] num_a_reg;
    logic [COORD_BITS-1:0] den_a_reg;
    a2ol_oct_t             oct_a_reg;
    logic                  b_valid_reg;
    logic [PROD_W-1:0]     prod_reg;
    logic [COORD_BITS-1:0] den_b_reg;
    a2ol_oct_t             oct_b_reg;

    logic                  ready_a;
    logic                  ready_b;
    logic [COORD_BITS-1:0] abs_y;
    logic [COORD_BITS-1:0] abs_x;
    logic [COORD_BITS-1:0] num_next;
    logic [COORD_BITS-1:0] den_next;
    a2ol_oct_t             oct_next;
    logic [PROD_W-1:0]     prod_next;

    assign ready_b  = !b_valid_reg || dn_ready;
    assign ready_a  = !a_valid_reg || ready_b;
    assign up_ready = ready_a;

    // magnitude at full width: the most negative input maps to 2^(n-1)
    always_comb
    begin
        abs_y          = delta_y[COORD_BITS-1] ? (~delta_y + 1'b1) : delta_y;
        abs_x          = delta_x[COORD_BITS-1] ? (~delta_x + 1'b1) : delta_x;
        oct_next.zero  = (delta_y == '0) && (delta_x == '0);
        oct_next.steep = abs_y > abs_x;
        oct_next.neg_x = delta_x[COORD_BITS-1];
        oct_next.neg_y = delta_y[COORD_BITS-1];
        num_next       = oct_next.steep ? abs_x : abs_y;
        den_next       = oct_next.steep ? abs_y : abs_x;
    end

    assign prod_next = PROD_W'(num_a_reg) * PROD_W'(TABLE_SIZE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            if (ready_a)
            begin
                a_valid_reg <= up_valid;
            end
            if (ready_b)
            begin
                b_valid_reg <= a_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_valid && ready_a)
        begin
            num_a_reg <= num_next;
            den_a_reg <= den_next;
            oct_a_reg <= oct_next;
        end
        if (a_valid_reg && ready_b)
        begin
            prod_reg  <= prod_next;
            den_b_reg <= den_a_reg;
            oct_b_reg <= oct_a_reg;
        end
    end

    // num*N < den*2^q, so the top bits already sit below the divisor
    assign dn_valid = b_valid_reg;
    assign rem      = prod_reg[PROD_W-1:QUO_BITS];
    assign low      = prod_reg[QUO_BITS-1:0];
    assign den      = den_b_reg;
    assign oct      = oct_b_reg;

    `A2OL_ASSERT_NEXT(p_zero_flagged, up_valid && ready_a && delta_y == '0 && delta_x == '0, a_valid_reg && oct_a_reg.zero, "zero request not flagged")

endmodule

/* design/a2ol_div_cell.sv */
`timescale 1ns / 1ps
`include "atan2_octant_lookup_core_macros.svh"

module a2ol_div_cell import a2ol_pkg::*; #(
    parameter int COORD_BITS = 16,
    parameter int QUO_BITS   = 9
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  up_valid,
    output logic                  up_ready,
    input  logic [COORD_BITS-1:0] rem_in,
    input  logic [QUO_BITS-1:0]   low_in,
    input  logic [COORD_BITS-1:0] den_in,
    input  logic [QUO_BITS-1:0]   quo_in,
    input  a2ol_oct_t             oct_in,
    output logic                  dn_valid,
    input  logic                  dn_ready,
    output logic [COORD_BITS-1:0] rem_out,
    output logic [QUO_BITS-1:0]   low_out,
    output logic [COORD_BITS-1:0] den_out,
    output logic [QUO_BITS-1:0]   quo_out,
    output a2ol_oct_t             oct_out
);

    logic                  valid_reg;
    logic [COORD_BITS-1:0] rem_reg;
    logic [QUO_BITS-1:0]   low_reg;
    logic [COORD_BITS-1:0] den_reg;
    logic [QUO_BITS-1:0]   quo_reg;
    a2ol_oct_t             oct_reg;

    logic [COORD_BITS:0]   trial;
    logic [COORD_BITS:0]   diff;
    logic                  take;
    logic [COORD_BITS-1:0] rem_next;
    logic [QUO_BITS-1:0]   low_next;
    logic [QUO_BITS-1:0]   quo_next;

    assign up_ready = !valid_reg || dn_ready;

    // one restoring step: bring down the next dividend bit
    always_comb
    begin
        trial    = {rem_in, low_in[QUO_BITS-1]};
        diff     = trial - {1'b0, den_in};
        take     = trial >= {1'b0, den_in};
        rem_next = take ? diff[COORD_BITS-1:0] : trial[COORD_BITS-1:0];
        low_next = {low_in[QUO_BITS-2:0], 1'b0};
        quo_next = {quo_in[QUO_BITS-2:0], take};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_valid && up_ready)
        begin
            rem_reg <= rem_next;
            low_reg <= low_next;
            den_reg <= den_in;
            quo_reg <= quo_next;
            oct_reg <= oct_in;
        end
    end

    assign dn_valid = valid_reg;
    assign rem_out  = rem_reg;
    assign low_out  = low_reg;
    assign den_out  = den_reg;
    assign quo_out  = quo_reg;
    assign oct_out  = oct_reg;

    `A2OL_ASSERT_IMPL(p_rem_below_den, valid_reg && den_reg != '0, rem_reg < den_reg, "partial remainder not below divisor")

endmodule

/* design/a2ol_back.sv */
`timescale 1ns / 1ps
`include "atan2_octant_lookup_core_macros.svh"

module a2ol_back import a2ol_pkg::*; #(
    parameter int QUO_BITS   = 9,
    parameter int TABLE_SIZE = 256
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               up_valid,
    output logic               up_ready,
    input  logic [QUO_BITS-1:0] quo,
    input  a2ol_oct_t          oct,
    output logic               dn_valid,
    input  logic               dn_ready,
    output logic [ANGLE_W-1:0] angle
);

    localparam a2ol_trig_t SIN_TAB = trig_tab(1'b0);
    localparam a2ol_trig_t COS_TAB = trig_tab(1'b1);

    logic               valid_reg;
    logic [ANGLE_W-1:0] angle_reg;

    logic [7:0]         rom [0:TABLE_SIZE];
    logic [7:0]         rom_q;
    logic [OCT_W-1:0]   base;
    logic [ANGLE_W-1:0] angle_next;

    for (genvar g = 0; g <= TABLE_SIZE; g++)
    begin : g_rom
        localparam logic [7:0] ENTRY = atan_entry(g, TABLE_SIZE, SIN_TAB, COS_TAB);
        assign rom[g] = ENTRY;
    end

    assign up_ready = !valid_reg || dn_ready;

    always_comb
    begin
        rom_q = rom[quo];
        base  = oct.steep ? (OCT_W'(QUARTER_TURN) - OCT_W'(rom_q)) : OCT_W'(rom_q);
        if (oct.zero)
        begin
            angle_next = '0;
        end
        else if (!oct.neg_x && !oct.neg_y)
        begin
            angle_next = ANGLE_W'(base);
        end
        else if (oct.neg_x && !oct.neg_y)
        begin
            angle_next = ANGLE_W'(HALF_TURN) - ANGLE_W'(base);
        end
        else if (oct.neg_x)
        begin
            angle_next = ANGLE_W'(HALF_TURN) + ANGLE_W'(base);
        end
        else
        begin
            // just below the positive x axis this reaches a full turn, kept as is
            angle_next = ANGLE_W'(FULL_TURN) - ANGLE_W'(base);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_valid && up_ready)
        begin
            angle_reg <= angle_next;
        end
    end

    assign dn_valid = valid_reg;
    assign angle    = angle_reg;

    `A2OL_ASSERT_IMPL(p_quo_in_table, up_valid && !oct.zero, quo <= QUO_BITS'(TABLE_SIZE), "quotient beyond table")
    `A2OL_ASSERT_IMPL(p_angle_range, valid_reg, angle_reg <= ANGLE_W'(FULL_TURN), "angle beyond full turn")

endmodule

/* design/atan2_octant_lookup_core.sv */
`timescale 1ns / 1ps
`include "atan2_octant_lookup_core_macros.svh"
// channel  | handshake               | payload
// ---------+-------------------------+---------------------------------------
// vector   | vec_valid / vec_stall   | delta_y, delta_x (COORD_BITS, signed)
// angle    | angle_valid / angle_stall | angle (11 bits, 0..1024)
//
// One request per cycle sustained while angle_stall stays low; the stages are
// the magnitude stage, the multiply stage, one divider cell per quotient bit,
// then table lookup and quadrant fold into the output.
// Reset clears only the valid flags; the arctangent table is constant logic.
// Every stage is elastic, so a stalled angle only holds up requests once the
// bubbles ahead of it are used up.

module atan2_octant_lookup_core import a2ol_pkg::*; #(
    parameter int ATAN_TABLE_SIZE = 256,
    parameter int COORD_BITS      = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  vec_valid,
    output logic                  vec_stall,
    input  logic [COORD_BITS-1:0] delta_y,
    input  logic [COORD_BITS-1:0] delta_x,
    output logic                  angle_valid,
    input  logic                  angle_stall,
    output logic [ANGLE_W-1:0]    angle
);

    localparam int QUO_BITS = $clog2(ATAN_TABLE_SIZE + 1);

    logic                  front_ready;
    logic                  chain_valid [0:QUO_BITS];
    logic                  chain_ready [0:QUO_BITS];
    logic [COORD_BITS-1:0] chain_rem   [0:QUO_BITS];
    logic [QUO_BITS-1:0]   chain_low   [0:QUO_BITS];
    logic [COORD_BITS-1:0] chain_den   [0:QUO_BITS];
    logic [QUO_BITS-1:0]   chain_quo   [0:QUO_BITS];
    a2ol_oct_t             chain_oct   [0:QUO_BITS];

    a2ol_front #(
        .COORD_BITS (COORD_BITS),
        .QUO_BITS   (QUO_BITS),
        .TABLE_SIZE (ATAN_TABLE_SIZE)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (vec_valid),
        .up_ready (front_ready),
        .delta_y  (delta_y),
        .delta_x  (delta_x),
        .dn_valid (chain_valid[0]),
        .dn_ready (chain_ready[0]),
        .rem      (chain_rem[0]),
        .low      (chain_low[0]),
        .den      (chain_den[0]),
        .oct      (chain_oct[0])
    );

    assign chain_quo[0] = '0;
    assign vec_stall    = !front_ready;

    for (genvar g = 0; g < QUO_BITS; g++)
    begin : g_cell
        a2ol_div_cell #(
            .COORD_BITS (COORD_BITS),
            .QUO_BITS   (QUO_BITS)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (chain_valid[g]),
            .up_ready (chain_ready[g]),
            .rem_in   (chain_rem[g]),
            .low_in   (chain_low[g]),
            .den_in   (chain_den[g]),
            .quo_in   (chain_quo[g]),
            .oct_in   (chain_oct[g]),
            .dn_valid (chain_valid[g+1]),
            .dn_ready (chain_ready[g+1]),
            .rem_out  (chain_rem[g+1]),
            .low_out  (chain_low[g+1]),
            .den_out  (chain_den[g+1]),
            .quo_out  (chain_quo[g+1]),
            .oct_out  (chain_oct[g+1])
        );
    end

    a2ol_back #(
        .QUO_BITS   (QUO_BITS),
        .TABLE_SIZE (ATAN_TABLE_SIZE)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (chain_valid[QUO_BITS]),
        .up_ready (chain_ready[QUO_BITS]),
        .quo      (chain_quo[QUO_BITS]),
        .oct      (chain_oct[QUO_BITS]),
        .dn_valid (angle_valid),
        .dn_ready (!angle_stall),
        .angle    (angle)
    );

    // an empty output register frees every stage behind it
    `A2OL_ASSERT_IMPL(p_open_when_drained, !angle_valid, !vec_stall, "requests refused with output empty")

endmodule
